// ===== design/mwo_pkg.sv =====
// Shared types, constants and the sine table generator for the multi-waveform oscillator.
package mwo_pkg;

	localparam int unsigned SAMPLE_BITS = 16;
	localparam int unsigned ENTRY_BITS  = 15;
	localparam int unsigned PHASE_BITS  = 16;
	localparam int unsigned QUAD_BITS   = 14;
	localparam int unsigned TAYLOR_TERMS = 12;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] ENTRY_MAX   = 64'd32767;

	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_SAW      = 2'd1,
		WAVE_SQUARE   = 2'd2,
		WAVE_TRIANGLE = 2'd3
	} wave_t;

	// Restoring long division; only ever evaluated while the table is built.
	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Quarter-wave entry k of a table with 2^tbits steps, Q0.15 magnitude.
	// The angle is rounded to Q30 and the Taylor series is summed in Q30.
	function automatic logic [ENTRY_BITS-1:0] sine_entry(input logic [31:0] k,
			input int unsigned tbits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		logic [63:0] dvs;
		x = (HALF_PI_Q30 * 64'(k) + (64'd1 << (tbits - 1))) >> tbits;
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (int unsigned n = 1; n <= TAYLOR_TERMS; n++) begin
			dvs = 64'((2 * n) * (2 * n + 1));
			term = (term * x2) >> 30;
			term = div_u64(term, dvs);
			if ((n & 1) == 1) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		v = (sum * 64'd32768 + (Q30_ONE >> 1)) >> 30;
		if (v > ENTRY_MAX) begin
			v = ENTRY_MAX;
		end
		return v[ENTRY_BITS-1:0];
	endfunction

endpackage

// ===== design/mwo_sine_rom.sv =====
// Quarter-wave sine ROM built at elaboration, with a registered read port.
module mwo_sine_rom
	import mwo_pkg::*;
#(
	parameter int unsigned TABLE_BITS = 10
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [TABLE_BITS:0]   addr,
	output logic [ENTRY_BITS-1:0] data
);

	localparam int unsigned DEPTH = (1 << TABLE_BITS) + 1;

	typedef logic [ENTRY_BITS-1:0] rom_t [DEPTH];

	function automatic rom_t build_rom();
		rom_t r;
		for (int unsigned k = 0; k < DEPTH; k++) begin
			r[k] = sine_entry(32'(k), TABLE_BITS);
		end
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	always_ff @(posedge clk) begin
		if (en) begin
			data <= ROM[addr];
		end
	end

endmodule

// ===== design/multi_waveform_oscillator.sv =====
// Top level of the multi-waveform oscillator: phase multiply, shape generation, output.
//
// Each item carries a frequency (unsigned Q16.8 Hz) and a sample time (unsigned Q8.24 s);
// the phase is the top 16 fraction bits of their product, and the result is one signed
// Q1.15 sample of the shape chosen by the waveform register (0 sine, 1 saw, 2 square,
// 3 triangle). The block accepts one item per cycle unless the output stalls, and each result
// passes through these stages in order: stage 1 holds the two partial products of the phase multiply,
// stage 2 adds them into the phase and forms the table address, stage 3 is the registered
// read of the quarter-wave sine ROM beside the saw, square and triangle values, and stage
// 4 is the output register. A stalled output holds the pipeline in place, and bubbles
// are squeezed out, so back pressure loses no item. Write the waveform register only
// while no item is in flight.
module multi_waveform_oscillator
	import mwo_pkg::*;
#(
	parameter int unsigned SINE_TABLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   waveform_we,
	input  logic [1:0]             waveform_wdata,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [23:0]            frequency,
	input  logic [31:0]            sample_time,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample
);

	localparam logic [SINE_TABLE_BITS:0] TABLE_N = (SINE_TABLE_BITS+1)'(1) << SINE_TABLE_BITS;

	wave_t waveform_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	logic [39:0] prod_lo;
	logic [31:0] prod_hi;
	logic [15:0] part_lo_s1, part_hi_s1;

	logic [PHASE_BITS-1:0] phase;
	logic [SINE_TABLE_BITS-1:0] tab_idx;
	logic [SINE_TABLE_BITS:0] tab_addr;
	logic [PHASE_BITS-1:0] phase_s2;
	logic [SINE_TABLE_BITS:0] addr_s2;

	logic [ENTRY_BITS-1:0] entry_s3;
	logic neg_s3;
	logic signed [SAMPLE_BITS-1:0] saw_s3, square_s3, tri_s3;

	logic [15:0] tri_mag;
	logic signed [SAMPLE_BITS-1:0] sine_val;

	// A stage loads when it is empty or its content moves on in the same cycle.
	assign en_s4 = !valid_s4 || out_ready;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign in_ready = en_s1;
	assign out_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q <= WAVE_SINE;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (waveform_we) begin
				waveform_q <= wave_t'(waveform_wdata);
			end
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	// Product bits 31:16 are the low product's bits 31:16 plus the low half of the high
	// product; nothing below bit 16 can carry into them.
	assign prod_lo = 40'(frequency) * 40'(sample_time[15:0]);
	assign prod_hi = 32'(frequency[15:0]) * 32'(sample_time[31:16]);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			part_lo_s1 <= prod_lo[31:16];
			part_hi_s1 <= prod_hi[15:0];
		end
	end

	assign phase = part_lo_s1 + part_hi_s1;
	assign tab_idx = phase[QUAD_BITS-1 -: SINE_TABLE_BITS];
	// Odd quadrants read the table backward from the peak entry.
	assign tab_addr = phase[QUAD_BITS] ? (TABLE_N - {1'b0, tab_idx}) : {1'b0, tab_idx};

	always_ff @(posedge clk) begin
		if (en_s2) begin
			phase_s2 <= phase;
			addr_s2 <= tab_addr;
		end
	end

	mwo_sine_rom #(
		.TABLE_BITS(SINE_TABLE_BITS)
	) u_rom (
		.clk (clk),
		.en  (en_s3),
		.addr(addr_s2),
		.data(entry_s3)
	);

	// Triangle magnitude |P - 32768| lies in 0..32768; only 32768 saturates.
	assign tri_mag = phase_s2[15] ? {1'b0, phase_s2[14:0]} : (16'h8000 - phase_s2);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			neg_s3 <= phase_s2[15];
			saw_s3 <= {~phase_s2[15], phase_s2[14:0]};
			square_s3 <= (phase_s2 != '0 && !phase_s2[15]) ? 16'sh7FFF : 16'sh8000;
			tri_s3 <= tri_mag[15] ? 16'sh7FFF : {~tri_mag[14], tri_mag[13:0], 1'b0};
		end
	end

	assign sine_val = neg_s3 ? -$signed({1'b0, entry_s3}) : $signed({1'b0, entry_s3});

	always_ff @(posedge clk) begin
		if (en_s4) begin
			unique case (waveform_q)
				WAVE_SINE:     sample <= sine_val;
				WAVE_SAW:      sample <= saw_s3;
				WAVE_SQUARE:   sample <= square_s3;
				WAVE_TRIANGLE: sample <= tri_s3;
				default:       sample <= sine_val;
			endcase
		end
	end

endmodule
